@@ rtl/gmcp_pkg.sv @@
// shared widths, types and helpers for the grid minimum-cost path unit
package gmcp_pkg;

   localparam int MAX_ROWS  = 128;
   localparam int MAX_COLS  = 128;
   localparam int CELL_W    = 16;
   localparam int COST_W    = 24;
   localparam int CNT_W     = 8;
   localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(128);

   typedef logic signed [CELL_W-1:0] cell_type;
   typedef logic signed [COST_W-1:0] cost_type;
   typedef logic [ROW_IDX_W-1:0]     row_idx_type;
   typedef logic [COL_IDX_W-1:0]     col_idx_type;

   // control handed from the top level to the row line
   typedef struct packed {
      logic        shift_en;
      col_idx_type last_col;
   } line_ctrl_type;

   // index of the last row in use: zero counts as one, large counts saturate
   function automatic row_idx_type last_row_of(input logic [CNT_W-1:0] cnt);
      row_idx_type res;
      res = '0;
      if (cnt == '0) begin
         res = '0;
      end else if (32'(cnt) > MAX_ROWS) begin
         res = ROW_IDX_W'(MAX_ROWS - 1);
      end else begin
         res = ROW_IDX_W'(cnt - CNT_W'(1));
      end
      return res;
   endfunction

   function automatic col_idx_type last_col_of(input logic [CNT_W-1:0] cnt);
      col_idx_type res;
      res = '0;
      if (cnt == '0) begin
         res = '0;
      end else if (32'(cnt) > MAX_COLS) begin
         res = COL_IDX_W'(MAX_COLS - 1);
      end else begin
         res = COL_IDX_W'(cnt - CNT_W'(1));
      end
      return res;
   endfunction

   function automatic cost_type min_cost(input cost_type a, input cost_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

@@ rtl/gmcp_cell.sv @@
// one stage of the previous-row cost line
module gmcp_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  logic              load_sel,
   input  gmcp_pkg::cost_type new_value,
   input  gmcp_pkg::cost_type next_value,
   output gmcp_pkg::cost_type value
);
   import gmcp_pkg::*;

   cost_type value_ff;
   cost_type value_in;

   // the insertion cell takes the fresh cost, the others take their neighbour's
   always_comb begin
      value_in = value_ff;
      if (shift_en) begin
         value_in = load_sel ? new_value : next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ rtl/gmcp_line.sv @@
// chain of cells holding the previous row of partial costs
module gmcp_line (
   input  logic                   clock,
   input  gmcp_pkg::line_ctrl_type ctrl,
   input  gmcp_pkg::cost_type      new_value,
   output gmcp_pkg::cost_type      head_value
);
   import gmcp_pkg::*;

   cost_type cell_value [MAX_COLS];

   // a cost enters at the last column in use and reaches cell 0 one row later
   for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
      cost_type next_value;
      logic     load_sel;

      if (i == MAX_COLS - 1) begin : g_tail
         assign next_value = new_value;
      end else begin : g_body
         assign next_value = cell_value[i+1];
      end

      assign load_sel = (ctrl.last_col == COL_IDX_W'(i));

      gmcp_cell u_cell (
         .clock      (clock),
         .shift_en   (ctrl.shift_en),
         .load_sel   (load_sel),
         .new_value  (new_value),
         .next_value (next_value),
         .value      (cell_value[i])
      );
   end

   assign head_value = cell_value[0];

endmodule

@@ rtl/grid_min_cost_path_unit.sv @@
// Grid minimum-cost path unit: top level with cost update and handshakes.
//
// Requests carry one signed 16-bit cell cost each, in row-major order over a
// grid of csr row_count rows by col_count columns (zero counts as one, counts
// above 128 saturate). A path runs from top-left to bottom-right moving down,
// right or diagonally; the block returns one 24-bit signed minimum path cost
// on the response channel when the bottom-right cell is taken, then starts a
// new grid. Other cells give no response.
// One request is taken per cycle unless stalled; the response appears in
// the cycle after the last cell is taken. The rate is set by the single add,
// three-way minimum and saturate between the line head and left-cost register.
// The previous row lives in a chain of 128 cells that shifts on each request.
// A csr write restarts the grid at the top-left cell; write only when idle.
// Reset restores both counts to 128 and restarts the grid.
// While a response waits and rsp_stall is high, requests keep being taken
// until the last cell of the next grid, which is held off until the response
// leaves.
module grid_min_cost_path_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gmcp_pkg::cell_type              req_cell_cost,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gmcp_pkg::cost_type              rsp_path_cost,
   input  logic                            csr_write,
   input  logic [gmcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gmcp_pkg::CNT_W-1:0]      csr_wdata
);
   import gmcp_pkg::*;

   localparam cost_type COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
   localparam cost_type COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

   logic [CNT_W-1:0] row_count_ff, row_count_in;
   logic [CNT_W-1:0] col_count_ff, col_count_in;
   row_idx_type      row_idx_ff, row_idx_in;
   col_idx_type      col_idx_ff, col_idx_in;
   cost_type         left_ff, left_in;
   cost_type         upleft_ff, upleft_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cost_type         rsp_cost_ff, rsp_cost_in;

   row_idx_type      last_row;
   col_idx_type      last_col;
   logic             at_last_col;
   logic             at_last_cell;
   logic             req_accept;
   cost_type         above;
   cost_type         base;
   logic signed [COST_W:0] sum;
   cost_type         new_cost;
   line_ctrl_type    line_ctrl;

   assign last_row     = last_row_of(row_count_ff);
   assign last_col     = last_col_of(col_count_ff);
   assign at_last_col  = (col_idx_ff == last_col);
   assign at_last_cell = at_last_col && (row_idx_ff == last_row);

   // only the grid's last cell needs the response register free
   assign req_stall  = rsp_valid_ff && rsp_stall && at_last_cell;
   assign req_accept = req_valid && !req_stall;

   assign line_ctrl.shift_en = req_accept;
   assign line_ctrl.last_col = last_col;

   gmcp_line u_line (
      .clock      (clock),
      .ctrl       (line_ctrl),
      .new_value  (new_cost),
      .head_value (above)
   );

   always_comb begin
      priority if (row_idx_ff == '0 && col_idx_ff == '0) begin
         base = '0;
      end else if (row_idx_ff == '0) begin
         base = left_ff;
      end else if (col_idx_ff == '0) begin
         base = above;
      end else begin
         base = min_cost(left_ff, min_cost(above, upleft_ff));
      end
   end

   assign sum = {base[COST_W-1], base} + (COST_W+1)'(req_cell_cost);

   // saturate to the 24-bit signed range
   always_comb begin
      if (sum[COST_W] != sum[COST_W-1]) begin
         new_cost = sum[COST_W] ? COST_MIN : COST_MAX;
      end else begin
         new_cost = sum[COST_W-1:0];
      end
   end

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      row_idx_in   = row_idx_ff;
      col_idx_in   = col_idx_ff;
      left_in      = left_ff;
      upleft_in    = upleft_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cost_in  = rsp_cost_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata;
            default:       row_count_in = row_count_ff;
         endcase
         row_idx_in = '0;
         col_idx_in = '0;
      end else if (req_accept) begin
         left_in   = new_cost;
         upleft_in = above;
         if (at_last_col) begin
            col_idx_in = '0;
            if (at_last_cell) begin
               row_idx_in   = '0;
               rsp_valid_in = 1'b1;
               rsp_cost_in  = new_cost;
            end else begin
               row_idx_in = row_idx_ff + ROW_IDX_W'(1);
            end
         end else begin
            col_idx_in = col_idx_ff + COL_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= COUNT_RESET;
         col_count_ff <= COUNT_RESET;
         row_idx_ff   <= '0;
         col_idx_ff   <= '0;
         left_ff      <= '0;
         upleft_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         row_idx_ff   <= row_idx_in;
         col_idx_ff   <= col_idx_in;
         left_ff      <= left_in;
         upleft_ff    <= upleft_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cost_ff <= rsp_cost_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_path_cost = rsp_cost_ff;

endmodule

@@ bench/tb.sv @@
// self-checking bench for the grid minimum-cost path unit: directed table, then random grids
module tb;
   import gmcp_pkg::*;

   localparam int COST_HI       = 2 ** (COST_W - 1) - 1;
   localparam int COST_LO       = -(2 ** (COST_W - 1));
   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_CELLS  = 1100;
   localparam int RANDOM_GRIDS  = 15;
   localparam int PLAN_ROWS     = 24;

   typedef enum logic {STEP_SIZE, STEP_CELLS} step_kind_type;

   typedef struct {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] reg_index;
      int                   count_value;
      int                   cost;
      int                   copies;
      bit                   typed;
      int                   typed_total;
   } step_type;

   logic                 clock;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   cell_type             req_cell_cost = '0;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   cost_type             rsp_path_cost;
   logic                 csr_write     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   logic [CNT_W-1:0]     csr_wdata     = '0;

   // path-cost prediction state
   cost_type prev_row_cost [MAX_COLS];
   cost_type left_acc;
   cost_type upleft_acc;
   int       row_pos;
   int       col_pos;
   int       rows_setting;
   int       cols_setting;
   cost_type expected_costs [$];
   cost_type popped_cost;

   bit steady = 1'b0;
   int error_count;
   int grids_checked;
   int grids_predicted;
   int cells_sent;
   int size_writes;
   int quiet_cycles;

   // cells rows repeat one cost; typed totals are read straight off the grid shape
   step_type directed_plan [PLAN_ROWS] = '{
      '{STEP_SIZE,  CSR_ROW_COUNT,   0,      0,     0, 1'b0,        0},
      '{STEP_SIZE,  CSR_COL_COUNT,   0,      0,     0, 1'b0,        0},
      '{STEP_CELLS, CSR_ROW_COUNT,   0,  32767,     1, 1'b1,    32767},
      '{STEP_CELLS, CSR_ROW_COUNT,   0, -32768,     1, 1'b1,   -32768},
      '{STEP_CELLS, CSR_ROW_COUNT,   0,      0,     1, 1'b1,        0},
      '{STEP_SIZE,  CSR_ROW_COUNT,   1,      0,     0, 1'b0,        0},
      '{STEP_SIZE,  CSR_COL_COUNT,   2,      0,     0, 1'b0,        0},
      '{STEP_CELLS, CSR_ROW_COUNT,   0,      5,     1, 1'b0,        0},
      '{STEP_CELLS, CSR_ROW_COUNT,   0,     -7,     1, 1'b1,       -2},
      '{STEP_SIZE,  CSR_ROW_COUNT,   2,      0,     0, 1'b0,        0},
      '{STEP_CELLS, CSR_ROW_COUNT,   0,      1,     1, 1'b0,        0},
      '{STEP_CELLS, CSR_ROW_COUNT,   0,      2,     1, 1'b0,        0},
      '{STEP_CELLS, CSR_ROW_COUNT,   0,      3,     1, 1'b0,        0},
      '{STEP_SIZE,  CSR_COL_COUNT,   2,      0,     0, 1'b0,        0},
      '{STEP_CELLS, CSR_ROW_COUNT,   0,    100,     4, 1'b1,      200},
      '{STEP_SIZE,  CSR_ROW_COUNT, 200,      0,     0, 1'b0,        0},
      '{STEP_SIZE,  CSR_COL_COUNT,   1,      0,     0, 1'b0,        0},
      '{STEP_CELLS, CSR_ROW_COUNT,   0,  32767,   128, 1'b1,  4194176},
      '{STEP_SIZE,  CSR_ROW_COUNT,   1,      0,     0, 1'b0,        0},
      '{STEP_SIZE,  CSR_COL_COUNT, 255,      0,     0, 1'b0,        0},
      '{STEP_CELLS, CSR_ROW_COUNT,   0, -32768,   128, 1'b1, -4194304},
      '{STEP_SIZE,  CSR_ROW_COUNT,   2,      0,     0, 1'b0,        0},
      '{STEP_SIZE,  CSR_COL_COUNT, 129,      0,     0, 1'b0,        0},
      '{STEP_CELLS, CSR_ROW_COUNT,   0,     -1,   256, 1'b1,     -129}
   };

   grid_min_cost_path_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cell_cost (req_cell_cost),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_path_cost (rsp_path_cost),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic int usable_count(input int setting, input int bound);
      if (setting == 0) return 1;
      return (setting > bound) ? bound : setting;
   endfunction

   // fold one cell into the running partial costs; returns 1 on the bottom-right cell
   function automatic bit fold_cell(input cell_type cost, output cost_type total);
      cost_type above;
      cost_type best;
      longint   sum;
      bit       done;
      above = prev_row_cost[col_pos];
      if (row_pos == 0 && col_pos == 0) begin
         sum = cost;
      end else if (row_pos == 0) begin
         sum = longint'(left_acc) + cost;
      end else if (col_pos == 0) begin
         sum = longint'(above) + cost;
      end else begin
         best = left_acc;
         if (above < best) best = above;
         if (upleft_acc < best) best = upleft_acc;
         sum = longint'(best) + cost;
      end
      if (sum > COST_HI) sum = COST_HI;
      else if (sum < COST_LO) sum = COST_LO;
      left_acc   = cost_type'(sum);
      upleft_acc = above;
      prev_row_cost[col_pos] = left_acc;
      total = left_acc;
      done  = 1'b0;
      if (col_pos + 1 >= usable_count(cols_setting, MAX_COLS)) begin
         col_pos = 0;
         if (row_pos + 1 >= usable_count(rows_setting, MAX_ROWS)) begin
            row_pos = 0;
            done    = 1'b1;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
      return done;
   endfunction

   task automatic send_cell(input cell_type cost, input bit use_typed,
                            input cost_type typed_total);
      bit       taken;
      cost_type total;
      while (!steady && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cell_cost <= cost;
      taken = 1'b0;
      // stall is stable mid-cycle, so sample it there
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      cells_sent++;
      if (fold_cell(cost, total)) begin
         expected_costs.push_back(use_typed ? typed_total : total);
         grids_predicted++;
      end
   endtask

   // hold the sender until every pending result is back, then let the pipeline empty
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (expected_costs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CNT_W'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (idx == CSR_ROW_COUNT) rows_setting = value & 8'hff;
      else cols_setting = value & 8'hff;
      row_pos = 0;
      col_pos = 0;
      size_writes++;
   endtask

   function automatic int pick_count();
      int sel;
      sel = $urandom_range(99);
      if (sel < 8) return 0;
      if (sel < 16) return $urandom_range(255, 129);
      if (sel < 22) return MAX_ROWS;
      if (sel < 40) return $urandom_range(32, 9);
      return $urandom_range(8, 1);
   endfunction

   function automatic cell_type pick_cost();
      int sel;
      sel = $urandom_range(99);
      if (sel < 10) return cell_type'(32767);
      if (sel < 20) return cell_type'(-32768);
      if (sel < 50) return cell_type'(int'($urandom_range(20)) - 10);
      return cell_type'($urandom_range(65535));
   endfunction

   task automatic run_phase();
      int rows;
      int cols;
      int swap;
      int cells;
      rows = pick_count();
      cols = pick_count();
      // keep grids small: past 256 cells, the column count drops to two or less
      if (usable_count(rows, MAX_ROWS) * usable_count(cols, MAX_COLS) > 256)
         cols = $urandom_range(2);
      if ($urandom_range(1)) begin
         swap = rows;
         rows = cols;
         cols = swap;
      end
      cells = usable_count(rows, MAX_ROWS) * usable_count(cols, MAX_COLS);
      drain_and_settle();
      if ($urandom_range(1)) begin
         write_count(CSR_ROW_COUNT, rows);
         write_count(CSR_COL_COUNT, cols);
      end else begin
         write_count(CSR_COL_COUNT, cols);
         write_count(CSR_ROW_COUNT, rows);
      end
      repeat ($urandom_range(4, 1)) begin
         if ($urandom_range(9) == 0) drain_and_settle();
         repeat (cells) send_cell(pick_cost(), 1'b0, '0);
      end
      // now and then a grid is left unfinished and dropped by the next size write
      if (cells > 1 && $urandom_range(4) == 0)
         repeat ($urandom_range(cells - 1, 1)) send_cell(pick_cost(), 1'b0, '0);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 16);
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_costs.size() == 0) begin
               $error("path_cost: expected none, actual %0d", rsp_path_cost);
               error_count++;
            end else begin
               popped_cost = expected_costs.pop_front();
               if (rsp_path_cost !== popped_cost) begin
                  $error("path_cost: expected %0d, actual %0d", popped_cost, rsp_path_cost);
                  error_count++;
               end else begin
                  grids_checked++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else if (++quiet_cycles >= QUIET_LIMIT) begin
            $display("no request or result moved for %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      int first_cell;
      int first_grid;
      int phase;
      foreach (prev_row_cost[i]) prev_row_cost[i] = '0;
      left_acc     = '0;
      upleft_acc   = '0;
      row_pos      = 0;
      col_pos      = 0;
      rows_setting = COUNT_RESET;
      cols_setting = COUNT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[n]) begin
         if (directed_plan[n].kind == STEP_SIZE) begin
            drain_and_settle();
            write_count(directed_plan[n].reg_index, directed_plan[n].count_value);
         end else begin
            for (int k = 1; k <= directed_plan[n].copies; k++)
               send_cell(cell_type'(directed_plan[n].cost),
                         directed_plan[n].typed && k == directed_plan[n].copies,
                         cost_type'(directed_plan[n].typed_total));
         end
      end

      first_cell = cells_sent;
      first_grid = grids_predicted;
      phase      = 0;
      while (cells_sent - first_cell < RANDOM_CELLS ||
             grids_predicted - first_grid < RANDOM_GRIDS) begin
         steady = (phase >= 4 && phase < 10);
         run_phase();
         phase++;
      end
      steady = 1'b0;

      drain_and_settle();
      repeat (8) @(posedge clock);
      $display("covered %0d cells and %0d checked path costs over %0d size writes",
               cells_sent, grids_checked, size_writes);
      $display("random part: %0d grid settings, extremes of both counts and cell costs",
               phase);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/gmcp_pkg.sv
rtl/gmcp_cell.sv
rtl/gmcp_line.sv
rtl/grid_min_cost_path_unit.sv
bench/tb.sv
